>>> hw/rtl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 digest block.
package sha1md_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 512;
   localparam int unsigned SLOT_W  = 6;
   localparam int unsigned ROUND_W = 7;
   localparam int unsigned LEN_W   = 64;
   localparam int unsigned WNUM_W  = 3;

   localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
   localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
   localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

   localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   localparam logic [SLOT_W-1:0]  SLOT_LAST = 6'd63;
   localparam logic [SLOT_W-1:0]  SLOT_LEN  = 6'd56;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
   localparam logic [WNUM_W-1:0]  DIGEST_WORDS = 3'd5;
   localparam logic [WNUM_W-1:0]  WORD_LAST = 3'd4;

   // working variables a..e
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
   } sha1md_vars_type;

   // schedule taps feeding the round unit
   typedef struct packed {
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w2;
      logic [WORD_W-1:0] w8;
      logic [WORD_W-1:0] w13;
   } sha1md_taps_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } sha1md_state_type;

endpackage

>>> hw/rtl/sha1md_round.sv
// One SHA-1 round: schedule expansion, round function and working-variable update.
module sha1md_round (
   input  sha1md_pkg::sha1md_vars_type         vars,
   input  sha1md_pkg::sha1md_taps_type         taps,
   input  logic [sha1md_pkg::ROUND_W-1:0]      round,
   output sha1md_pkg::sha1md_vars_type         vars_next,
   output logic [sha1md_pkg::WORD_W-1:0]       wt
);

   logic [sha1md_pkg::WORD_W-1:0] mix;
   logic [sha1md_pkg::WORD_W-1:0] f;
   logic [sha1md_pkg::WORD_W-1:0] k;
   logic [sha1md_pkg::WORD_W-1:0] t;

   assign mix = taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0;
   assign wt  = (round < 7'd16) ? taps.w0 : {mix[30:0], mix[31]};

   always_comb begin
      if (round < 7'd20) begin
         f = (vars.b & vars.c) | (~vars.b & vars.d);
         k = sha1md_pkg::K0;
      end else if (round < 7'd40) begin
         f = vars.b ^ vars.c ^ vars.d;
         k = sha1md_pkg::K1;
      end else if (round < 7'd60) begin
         f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
         k = sha1md_pkg::K2;
      end else begin
         f = vars.b ^ vars.c ^ vars.d;
         k = sha1md_pkg::K3;
      end
   end

   assign t = {vars.a[26:0], vars.a[31:27]} + f + vars.e + k + wt;

   assign vars_next.a = t;
   assign vars_next.b = vars.a;
   assign vars_next.c = {vars.b[1:0], vars.b[31:2]};
   assign vars_next.d = vars.c;
   assign vars_next.e = vars.d;

endmodule

>>> hw/rtl/sha1_message_digest.sv
// SHA-1 message digest over a byte stream, top level.
//
// Input channel (req_): one beat per message byte. req_tdata carries the byte,
// req_tuser[0] says whether the byte is present (0 on an empty end marker) and
// req_tlast closes the message. A beat with neither byte nor tlast does nothing.
// Result channel (rsp_): five beats per message, h0 first. rsp_tuser holds the
// word number 0..4 and rsp_tlast marks h4.
//
// Timing: bytes are taken one per cycle while tready is high. The 64th byte
// of a block starts the compression: 80 rounds through one shared round unit,
// one round per cycle, and then a step that folds the result into the chain
// value. At the end of a message the padding bytes are placed one per cycle
// with one or two compressions, then the digest moves into a five-word output
// buffer; tready is low during padding and compression.
// When the receiver stalls, the buffered digest holds and the next message can
// already be taken; a later digest waits until the buffer has drained.
// Reset (synchronous, active high) loads the initial chain value, clears the
// length and byte position, and empties the output buffer. No clearing pass.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_number
   output logic        rsp_tlast    // final_word
);

   localparam int unsigned WW = sha1md_pkg::WORD_W;
   localparam int unsigned BW = sha1md_pkg::BLOCK_W;

   sha1md_pkg::sha1md_state_type state_ff, state_in;

   // block buffer / schedule window: word 0 sits in the top bits
   logic [BW-1:0] sched_ff, sched_in;
   sha1md_pkg::sha1md_vars_type vars_ff, vars_in;
   sha1md_pkg::sha1md_vars_type chain_ff, chain_in;
   logic [sha1md_pkg::LEN_W-1:0]   bitlen_ff, bitlen_in;
   logic [sha1md_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [sha1md_pkg::ROUND_W-1:0] round_ff, round_in;
   logic closing_ff, closing_in;   // message end seen, padding pending
   logic mark_ff, mark_in;         // 0x80 marker placed
   logic lenph_ff, lenph_in;       // length bytes being placed

   logic [WW-1:0] obuf_ff [5];
   logic [WW-1:0] obuf_in [5];
   logic [sha1md_pkg::WNUM_W-1:0] ocnt_ff, ocnt_in;
   logic [sha1md_pkg::WNUM_W-1:0] oword_ff, oword_in;

   logic       req_acc;
   logic       rsp_acc;
   logic       put_en;
   logic [7:0] put_byte;

   sha1md_pkg::sha1md_taps_type taps;
   sha1md_pkg::sha1md_vars_type vars_next;
   logic [WW-1:0] wt;

   assign taps.w0  = sched_ff[BW-1      -: WW];
   assign taps.w2  = sched_ff[BW-1-2*WW -: WW];
   assign taps.w8  = sched_ff[BW-1-8*WW -: WW];
   assign taps.w13 = sched_ff[BW-1-13*WW -: WW];

   sha1md_round u_round (
      .vars      (vars_ff),
      .taps      (taps),
      .round     (round_ff),
      .vars_next (vars_next),
      .wt        (wt)
   );

   assign req_tready = (state_ff == sha1md_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (ocnt_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = obuf_ff[0];
   assign rsp_tuser  = oword_ff;
   assign rsp_tlast  = (oword_ff == sha1md_pkg::WORD_LAST);

   always_comb begin
      state_in   = state_ff;
      sched_in   = sched_ff;
      vars_in    = vars_ff;
      chain_in   = chain_ff;
      bitlen_in  = bitlen_ff;
      slot_in    = slot_ff;
      round_in   = round_ff;
      closing_in = closing_ff;
      mark_in    = mark_ff;
      lenph_in   = lenph_ff;
      put_en     = 1'b0;
      put_byte   = sha1md_pkg::PAD_ZERO;

      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_acc) begin
               put_en   = req_tuser[0];
               put_byte = req_tdata;
               if (req_tuser[0]) begin
                  bitlen_in = bitlen_ff + 64'd8;
               end
               closing_in = req_tlast;
               if (req_tuser[0] && (slot_ff == sha1md_pkg::SLOT_LAST)) begin
                  state_in = sha1md_pkg::ST_ROUND;
               end else if (req_tlast) begin
                  state_in = sha1md_pkg::ST_PAD;
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            put_en = 1'b1;
            if (!mark_ff) begin
               put_byte = sha1md_pkg::PAD_MARK;
               mark_in  = 1'b1;
            end else if (lenph_ff || (slot_ff == sha1md_pkg::SLOT_LEN)) begin
               // length goes out MSB first; the register ends up cleared
               put_byte  = bitlen_ff[63:56];
               bitlen_in = {bitlen_ff[55:0], 8'h00};
               lenph_in  = 1'b1;
            end
            if (slot_ff == sha1md_pkg::SLOT_LAST) begin
               state_in = sha1md_pkg::ST_ROUND;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            vars_in  = vars_next;
            sched_in = {sched_ff[BW-WW-1:0], wt};
            round_in = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::ROUND_LAST) begin
               round_in = '0;
               state_in = sha1md_pkg::ST_ADD;
            end
         end
         sha1md_pkg::ST_ADD: begin
            chain_in.a = chain_ff.a + vars_ff.a;
            chain_in.b = chain_ff.b + vars_ff.b;
            chain_in.c = chain_ff.c + vars_ff.c;
            chain_in.d = chain_ff.d + vars_ff.d;
            chain_in.e = chain_ff.e + vars_ff.e;
            if (!closing_ff) begin
               state_in = sha1md_pkg::ST_IDLE;
            end else if (lenph_ff) begin
               state_in = sha1md_pkg::ST_OUT;
            end else begin
               state_in = sha1md_pkg::ST_PAD;
            end
         end
         sha1md_pkg::ST_OUT: begin
            // wait for the output buffer, then start a fresh message
            if (ocnt_ff == '0) begin
               chain_in   = '{a: sha1md_pkg::IV0, b: sha1md_pkg::IV1,
                              c: sha1md_pkg::IV2, d: sha1md_pkg::IV3,
                              e: sha1md_pkg::IV4};
               closing_in = 1'b0;
               mark_in    = 1'b0;
               lenph_in   = 1'b0;
               state_in   = sha1md_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      if (put_en) begin
         sched_in = {sched_ff[BW-9:0], put_byte};
         slot_in  = slot_ff + 6'd1;
         if (slot_ff == sha1md_pkg::SLOT_LAST) begin
            vars_in = chain_ff;
         end
      end
   end

   // output buffer: load at digest time, shift on each accepted beat
   always_comb begin
      obuf_in  = obuf_ff;
      ocnt_in  = ocnt_ff;
      oword_in = oword_ff;
      if ((state_ff == sha1md_pkg::ST_OUT) && (ocnt_ff == '0)) begin
         obuf_in[0] = chain_ff.a;
         obuf_in[1] = chain_ff.b;
         obuf_in[2] = chain_ff.c;
         obuf_in[3] = chain_ff.d;
         obuf_in[4] = chain_ff.e;
         ocnt_in    = sha1md_pkg::DIGEST_WORDS;
         oword_in   = '0;
      end else if (rsp_acc) begin
         for (int i = 0; i < 4; i++) begin
            obuf_in[i] = obuf_ff[i+1];
         end
         ocnt_in  = ocnt_ff - 3'd1;
         oword_in = oword_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha1md_pkg::ST_IDLE;
         chain_ff   <= '{a: sha1md_pkg::IV0, b: sha1md_pkg::IV1,
                         c: sha1md_pkg::IV2, d: sha1md_pkg::IV3,
                         e: sha1md_pkg::IV4};
         bitlen_ff  <= '0;
         slot_ff    <= '0;
         round_ff   <= '0;
         closing_ff <= 1'b0;
         mark_ff    <= 1'b0;
         lenph_ff   <= 1'b0;
         ocnt_ff    <= '0;
         oword_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         bitlen_ff  <= bitlen_in;
         slot_ff    <= slot_in;
         round_ff   <= round_in;
         closing_ff <= closing_in;
         mark_ff    <= mark_in;
         lenph_ff   <= lenph_in;
         ocnt_ff    <= ocnt_in;
         oword_ff   <= oword_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
      obuf_ff  <= obuf_in;
   end

   // round counter only runs during compression
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sha1md_pkg::ST_ROUND) |-> (round_ff == '0))
      else $error("round counter active outside compression");

   // padding flags are clear whenever input is taken
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1md_pkg::ST_IDLE) |-> (!closing_ff && !mark_ff && !lenph_ff))
      else $error("padding flags set while accepting input");

   // a finished message leaves length and byte position cleared
   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sha1md_pkg::ST_OUT) && (ocnt_ff == '0))
      |=> ((bitlen_ff == '0) && (slot_ff == '0) && (ocnt_ff == sha1md_pkg::DIGEST_WORDS)))
      else $error("message state not cleared at digest hand-off");

   // the marked last word is the last one in the buffer
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (ocnt_ff == 3'd1))
      else $error("last digest word out of step with buffer count");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the SHA-1 byte-stream digest block.
`timescale 1ns / 100ps

module tb;

   // ---------------------------------------------------------------------
   // Run sizing
   // ---------------------------------------------------------------------
   localparam int RANDOM_ITEMS   = 400;   // byte / end beats in the random part
   localparam int LONG_HOLD      = 600;   // cycles the receiver blocks once
   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any beat moving
   localparam int SETTLE_CYCLES  = 300;   // look for stray results after drain

   // One input beat plus, for directed rows, an optional typed-in digest.
   // The digest is packed h0 in the top word down to h4 in the bottom word.
   typedef struct packed {
      logic [7:0]   data;
      logic         present;
      logic         last;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   // One expected result beat
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   typedef enum int {
      RX_STEADY,   // always ready
      RX_COIN,     // ready half the time
      RX_SPARSE,   // ready a quarter of the time
      RX_MOSTLY    // ready nine tenths of the time
   } rx_mode_type;

   localparam logic [159:0] EMPTY_DIGEST =
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST =
      160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
   localparam logic [159:0] NO_DIGEST = '0;

   // Directed table: data, present, last, known, digest.
   // Rows with known = 0 are checked against the predictor.
   localparam int DIR_N = 14;
   localparam stim_row_type DIRECTED [DIR_N] = '{
      {8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}, // empty message right after reset
      {8'hA5, 1'b0, 1'b0, 1'b0, NO_DIGEST},    // neither byte nor end: no effect
      {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},    // "a"
      {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},    // "b"
      {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},   // "c" with end: byte taken first
      {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},    // lowest byte
      {8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},    // highest byte
      {8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},    // separate end marker
      {8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},    // one-byte message, all ones
      {8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},    // one-byte message, zero
      {8'h5A, 1'b0, 1'b0, 1'b0, NO_DIGEST},    // idle beat between messages
      {8'h3C, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}, // empty again, state restarted
      {8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h7F, 1'b1, 1'b1, 1'b0, NO_DIGEST}
   };

   // ---------------------------------------------------------------------
   // DUT connections
   // ---------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic [0:0]  req_tuser;    // [0] byte_present
   logic        req_tlast;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] digest_word
   logic [2:0]  rsp_tuser;    // [2:0] word_number
   logic        rsp_tlast;    // final_word

   sha1_message_digest dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Digest predictor: chain value, 16-word block buffer, running length
   // ---------------------------------------------------------------------
   logic [31:0] chain_h [5];
   logic [31:0] block_w [16];
   logic [63:0] msg_bits;
   logic [5:0]  fill_slot;

   digest_beat_type digest_q [$];   // digest words still owed by the block

   int errors;
   int results_checked;
   int messages_done;
   int counted_items;
   int noise_items;
   int longest_msg;
   int burst_left;
   int idle_cycles;
   bit hold_pending;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic restart_message();
      chain_h[0] = sha1md_pkg::IV0;
      chain_h[1] = sha1md_pkg::IV1;
      chain_h[2] = sha1md_pkg::IV2;
      chain_h[3] = sha1md_pkg::IV3;
      chain_h[4] = sha1md_pkg::IV4;
      msg_bits   = '0;
      fill_slot  = '0;
   endtask

   // 80 rounds over the current block, folded into the chain value
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, t, wt, k;
      int r;
      for (r = 0; r < 16; r++)
         w[r] = block_w[r];
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (r = 0; r < 80; r++) begin
         if (r < 16) begin
            wt = w[r];
         end else begin
            // schedule kept as a rolling 16-word window
            wt = rotate_left(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                             w[(r + 2) % 16] ^ w[r % 16], 1);
            w[r % 16] = wt;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K3;
         end
         t = rotate_left(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endtask

   // big-endian byte placement; the 64th byte triggers compression
   task automatic absorb_byte(input logic [7:0] b);
      logic [3:0] idx;
      int shift;
      idx   = fill_slot[5:2];
      shift = (3 - fill_slot[1:0]) * 8;
      if (fill_slot[1:0] == 2'd0)
         block_w[idx] = {24'd0, b} << shift;
      else
         block_w[idx] |= {24'd0, b} << shift;
      if (fill_slot == sha1md_pkg::SLOT_LAST) begin
         fill_slot = '0;
         compress_block();
      end else begin
         fill_slot++;
      end
   endtask

   // apply one accepted beat; queue the five digest words on end of message
   task automatic predict_item(input stim_row_type it);
      logic [63:0] len;
      digest_beat_type beat;
      int k;
      if (it.present) begin
         absorb_byte(it.data);
         msg_bits += 64'd8;
      end
      if (it.last) begin
         len = msg_bits;
         absorb_byte(sha1md_pkg::PAD_MARK);
         while (fill_slot != sha1md_pkg::SLOT_LEN)
            absorb_byte(sha1md_pkg::PAD_ZERO);
         for (k = 7; k >= 0; k--)
            absorb_byte(len[8*k +: 8]);
         for (k = 0; k < 5; k++) begin
            beat.word  = it.known ? it.digest[159 - 32*k -: 32] : chain_h[k];
            beat.index = 3'(k);
            beat.last  = (3'(k) == sha1md_pkg::WORD_LAST);
            digest_q.push_back(beat);
         end
         if (int'(len >> 3) > longest_msg)
            longest_msg = int'(len >> 3);
         messages_done++;
         restart_message();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender side: bursts with random gaps, inputs change on the falling edge
   // ---------------------------------------------------------------------
   task automatic go_idle(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic offer_beat(input stim_row_type it);
      if (burst_left == 0) begin
         go_idle($urandom_range(1, 8));
         // now and then a long unbroken burst
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= it.data;
      req_tuser  <= it.present;
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      predict_item(it);
      if (it.present || it.last)
         counted_items++;
      else
         noise_items++;
   endtask

   // one well-formed message with random content and scattered idle beats
   task automatic send_message(input int len, input bit end_apart);
      stim_row_type it;
      int i;
      it = '0;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            it.data    = 8'($urandom);
            it.present = 1'b0;
            it.last    = 1'b0;
            offer_beat(it);
         end
         it.data    = 8'($urandom);
         it.present = 1'b1;
         it.last    = (i == len - 1) && !end_apart;
         offer_beat(it);
      end
      if (end_apart || len == 0) begin
         it.data    = 8'($urandom);   // ignored by the block
         it.present = 1'b0;
         it.last    = 1'b1;
         offer_beat(it);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: back-pressure pattern that changes mode every so often,
   // plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int left;
      mode = RX_STEADY;
      left = 0;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            // block long enough for the digest buffer and the core to fill
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
               RX_STEADY: begin
                  rsp_tready <= 1'b1;
               end
               RX_COIN: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               RX_SPARSE: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 9) != 0);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker and watchdog, sampled on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      digest_beat_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;

         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               $error("digest beat with nothing expected: word %h number %0d",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = digest_q.pop_front();
               results_checked++;
               if (rsp_tdata !== want.word) begin
                  $error("digest_word: expected %h, got %h", want.word, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== want.index) begin
                  $error("word_number: expected %0d, got %0d", want.index, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("final_word: expected %0d, got %0d", want.last, rsp_tlast);
                  errors++;
               end
            end
         end

         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d digest words still outstanding", digest_q.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main
      int i;
      int len;
      int pick;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      req_tlast       = 1'b0;
      hold_pending    = 1'b0;
      errors          = 0;
      results_checked = 0;
      messages_done   = 0;
      counted_items   = 0;
      noise_items     = 0;
      longest_msg     = 0;
      burst_left      = 0;
      for (i = 0; i < 16; i++)
         block_w[i] = '0;
      restart_message();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIR_N; i++)
         offer_beat(DIRECTED[i]);

      // sender pauses until every owed digest word is out
      go_idle(1);
      burst_left = 0;
      while (digest_q.size() != 0) @(posedge clock);

      // random part; the receiver blocks for a long stretch at its start
      hold_pending = 1'b1;
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 15);
         if (pick < 10)
            len = $urandom_range(1, 20);
         else if (pick < 13)
            len = $urandom_range(52, 66);    // padding spill and full-block edges
         else if (pick == 13)
            len = $urandom_range(119, 129);  // two blocks plus padding edges
         else if (pick == 14)
            len = $urandom_range(0, 2);
         else
            len = 0;
         // keep the total close to the planned item count
         if (len > RANDOM_ITEMS - counted_items)
            len = RANDOM_ITEMS - counted_items;
         send_message(len, $urandom_range(0, 1));
      end

      go_idle(1);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d messages up to %0d bytes long, directed and random,",
               messages_done, longest_msg);
      $display("with %0d idle beats mixed in; %0d digest words checked.",
               noise_items, results_checked);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sha1_message_digest.f
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_round.sv
hw/rtl/sha1_message_digest.sv
sim/tb.sv
